// ----- rtl/qmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qmm_pkg - motor mixer shared types and constants
// transfer structs for the item and result channels, register indexes,
// battery status codes and failsafe thresholds
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_LAYOUT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVR_REQ    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_1    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_2    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_3    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_4    = 4'd7;

  // battery status codes
  localparam logic [1:0] BAT_NORMAL    = 2'd0;
  localparam logic [1:0] BAT_LOW       = 2'd1;
  localparam logic [1:0] BAT_CRIT_WAIT = 2'd2;
  localparam logic [1:0] BAT_LANDING   = 2'd3;

  localparam logic [15:0] CRITICAL_MV      = 16'd12800;
  localparam logic [15:0] LOW_MV           = 16'd13500;
  localparam logic [31:0] OVR_TIMEOUT_MS   = 32'd5000;
  localparam logic [31:0] LANDING_DELAY_MS = 32'd2000;

  typedef struct packed {
    logic        [15:0] thrust_cmd;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic        [15:0] battery_mv;
    logic               is_armed;
    logic        [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] motor_1;
    logic [15:0] motor_2;
    logic [15:0] motor_3;
    logic [15:0] motor_4;
    logic        override_used;
    logic [1:0]  battery_status;
  } out_t;

endpackage

// ----- rtl/qmm_mix.sv -----
// ----------------------------------------------------------------------------
// qmm_mix - thrust scaling and four-motor mixing
// scales thrust by the battery factor, mixes in X or plus layout,
// saturates each drive to 16 bits and raises it to the idle level
// ----------------------------------------------------------------------------
module qmm_mix (
  input  qmm_pkg::in_t     item,
  input  logic             x_layout,
  input  logic [15:0]      idle_level,
  input  logic [1:0]       bat_status,
  output logic [3:0][15:0] drive
);
  import qmm_pkg::*;

  // ceil(2^23 / 10), exact for products below 2^22
  localparam logic [19:0] RECIP10 = 20'd838861;
  localparam int unsigned RECIP_SH = 23;

  logic        [18:0] prod_k;
  logic        [38:0] recip_prod;
  logic        [15:0] quot;
  logic        [15:0] thr_scaled;
  logic signed [18:0] t_s;
  logic signed [18:0] roll_s;
  logic signed [18:0] pitch_s;
  logic signed [18:0] yaw_s;
  logic signed [18:0] roll_h;
  logic signed [18:0] pitch_h;
  logic signed [18:0] sum [4];

  function automatic logic [15:0] sat_idle(input logic signed [18:0] v,
                                           input logic [15:0] lvl);
    logic [15:0] s;
    if (v[18]) begin
      s = 16'd0;
    end else if (v[17:16] != 2'd0) begin
      s = 16'hffff;
    end else begin
      s = v[15:0];
    end
    return (s < lvl) ? lvl : s;
  endfunction

  always_comb begin
    // thrust * 7 for low battery, thrust * 1 for landing, then divide by ten
    if (bat_status == BAT_LOW) begin
      prod_k = {item.thrust_cmd, 3'b000} - {3'b000, item.thrust_cmd};
    end else begin
      prod_k = {3'b000, item.thrust_cmd};
    end
  end

  assign recip_prod = {20'd0, prod_k} * {19'd0, RECIP10};
  assign quot       = recip_prod[RECIP_SH +: 16];

  always_comb begin
    case (bat_status)
      BAT_NORMAL:    thr_scaled = item.thrust_cmd;
      BAT_CRIT_WAIT: thr_scaled = {1'b0, item.thrust_cmd[15:1]};
      default:       thr_scaled = quot;
    endcase
  end

  assign t_s     = $signed({3'b000, thr_scaled});
  assign roll_s  = {{3{item.roll_cmd[15]}}, item.roll_cmd};
  assign pitch_s = {{3{item.pitch_cmd[15]}}, item.pitch_cmd};
  assign yaw_s   = {{3{item.yaw_cmd[15]}}, item.yaw_cmd};

  // halve toward zero
  assign roll_h  = (roll_s + $signed({18'd0, item.roll_cmd[15]})) >>> 1;
  assign pitch_h = (pitch_s + $signed({18'd0, item.pitch_cmd[15]})) >>> 1;

  always_comb begin
    if (x_layout) begin
      sum[0] = t_s - roll_h + pitch_h + yaw_s;
      sum[1] = t_s - roll_h - pitch_h - yaw_s;
      sum[2] = t_s + roll_h - pitch_h + yaw_s;
      sum[3] = t_s + roll_h + pitch_h - yaw_s;
    end else begin
      sum[0] = t_s + pitch_s + yaw_s;
      sum[1] = t_s - roll_s - yaw_s;
      sum[2] = t_s - pitch_s + yaw_s;
      sum[3] = t_s + roll_s - yaw_s;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      drive[i] = sat_idle(sum[i], idle_level);
    end
  end

endmodule

// ----- rtl/quad_motor_mixer_battery_failsafe.sv -----
// ----------------------------------------------------------------------------
// quad_motor_mixer_battery_failsafe - quadcopter motor mixer with failsafe
// battery-scaled thrust mixed into four motor drives, with a timed manual
// override and a critical-voltage landing timer
// ----------------------------------------------------------------------------
// The block takes one control item per clock cycle while no result waits
// under out_stall, and returns one result per item: the item lands in an input
// register, then the timer update, thrust scaling, mixing, saturation and
// override selection run combinationally into the result register. While a
// result waits under out_stall the input register still takes one more item.
// Configuration writes are always ready and take effect at once; they are
// meant to be made while no item is in flight.
// ----------------------------------------------------------------------------
module quad_motor_mixer_battery_failsafe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qmm_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qmm_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import qmm_pkg::*;

  // configuration
  logic             x_layout_r;
  logic [15:0]      idle_level_r;
  logic             failsafe_r;
  logic [3:0][15:0] ovr_drive_r;

  // state
  logic        ovr_active_r, ovr_active_nxt;
  logic [31:0] ovr_start_r, ovr_start_nxt;
  logic [31:0] crit_start_r, crit_start_nxt;
  logic        landing_r, landing_nxt;

  // pipeline
  logic             in_valid_r;
  in_t              in_r;
  logic             out_valid_r;
  out_t             out_r;
  logic             advance;
  logic             cfg_wr;

  logic             is_crit;
  logic             is_low;
  logic [31:0]      crit_eff;
  logic [31:0]      crit_elapsed;
  logic [31:0]      ovr_elapsed;
  logic [1:0]       bat_status;
  logic [3:0][15:0] mix_drive;
  out_t             res;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // override timing
  assign ovr_elapsed = in_r.now_ms - ovr_start_r;

  always_comb begin
    ovr_active_nxt = ovr_active_r;
    ovr_start_nxt  = ovr_start_r;
    if (ovr_active_r) begin
      if (in_r.is_armed) begin
        ovr_active_nxt = 1'b0;
        ovr_start_nxt  = 32'd0;
      end else if (ovr_start_r != 32'd0) begin
        if (ovr_elapsed > OVR_TIMEOUT_MS) begin
          ovr_active_nxt = 1'b0;
          ovr_start_nxt  = 32'd0;
        end
      end else begin
        ovr_start_nxt = in_r.now_ms;
      end
    end else begin
      ovr_start_nxt = 32'd0;
    end
  end

  // battery failsafe
  assign is_crit = failsafe_r && (in_r.battery_mv != 16'd0) && (in_r.battery_mv < CRITICAL_MV);
  assign is_low  = failsafe_r && (in_r.battery_mv != 16'd0) && (in_r.battery_mv < LOW_MV);
  assign crit_eff     = (crit_start_r == 32'd0) ? in_r.now_ms : crit_start_r;
  assign crit_elapsed = in_r.now_ms - crit_eff;

  always_comb begin
    crit_start_nxt = 32'd0;
    landing_nxt    = 1'b0;
    bat_status     = BAT_NORMAL;
    if (is_crit) begin
      crit_start_nxt = crit_eff;
      if (crit_elapsed >= LANDING_DELAY_MS) begin
        landing_nxt = 1'b1;
        bat_status  = BAT_LANDING;
      end else begin
        landing_nxt = landing_r;
        bat_status  = BAT_CRIT_WAIT;
      end
    end else if (is_low) begin
      bat_status = BAT_LOW;
    end
  end

  qmm_mix u_mix (
    .item       (in_r),
    .x_layout   (x_layout_r),
    .idle_level (idle_level_r),
    .bat_status (bat_status),
    .drive      (mix_drive)
  );

  always_comb begin
    res.override_used  = ovr_active_nxt;
    res.battery_status = bat_status;
    if (ovr_active_nxt) begin
      res.motor_1 = ovr_drive_r[0];
      res.motor_2 = ovr_drive_r[1];
      res.motor_3 = ovr_drive_r[2];
      res.motor_4 = ovr_drive_r[3];
    end else begin
      res.motor_1 = mix_drive[0];
      res.motor_2 = mix_drive[1];
      res.motor_3 = mix_drive[2];
      res.motor_4 = mix_drive[3];
    end
  end

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_layout_r   <= 1'b1;
      idle_level_r <= 16'd0;
      failsafe_r   <= 1'b1;
      ovr_drive_r  <= '0;
      ovr_active_r <= 1'b0;
      ovr_start_r  <= 32'd0;
      crit_start_r <= 32'd0;
      landing_r    <= 1'b0;
    end else begin
      if (advance) begin
        ovr_active_r <= ovr_active_nxt;
        ovr_start_r  <= ovr_start_nxt;
        crit_start_r <= crit_start_nxt;
        landing_r    <= landing_nxt;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_X_LAYOUT:   x_layout_r     <= cfg_data[0];
          CFG_IDLE_LEVEL: idle_level_r   <= cfg_data;
          CFG_FAILSAFE:   failsafe_r     <= cfg_data[0];
          CFG_OVR_REQ:    ovr_active_r   <= cfg_data[0];
          CFG_DRIVE_1:    ovr_drive_r[0] <= cfg_data;
          CFG_DRIVE_2:    ovr_drive_r[1] <= cfg_data;
          CFG_DRIVE_3:    ovr_drive_r[2] <= cfg_data;
          CFG_DRIVE_4:    ovr_drive_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // landing only follows a recorded critical start
  a_landing_timer: assert property (@(posedge clk) disable iff (!rst_n)
    landing_r |-> (crit_start_r != 32'd0))
    else $error("landing active without critical start time");

  // landing entry is reported in the same transfer
  a_landing_status: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(landing_r) |-> (out_valid_r && (out_r.battery_status == BAT_LANDING)))
    else $error("landing entry not reported as landing status");

  // an item is only held back while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a waiting result");

endmodule
